// ===== hw/rtl/baro_temp_pressure_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometer compensation block.
// Concurrent checks clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define BPTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion on the block's own clock and reset.
`define BPTC_ASSERT_CLK(label, prop, msg) \
    `BPTC_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 18;
    localparam int PRESS_W    = 32;
    localparam int CAL_W      = 48;
    localparam int DIV_STAGES = 64;
    localparam int DEN_W      = 31;

    // Pressure numerator scale factor.
    localparam logic [11:0] PRESS_SCALE = 12'd3125;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CAL_T  = 2'd0,
        REG_CAL_PA = 2'd1,
        REG_CAL_PB = 2'd2,
        REG_CAL_PC = 2'd3
    } t_cfg_reg;

    // Unpacked calibration words.
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_calib;

    // Side information that rides along the divider and the final stages.
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              dz;
        logic              neg;
    } t_tag;

endpackage

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// Throughput: one word per cycle while the skid register is empty.
// 83 register stages, 64 of them the divider, feed the output register.
// A skid register lets the input take one more word while a result waits.
// Reset clears valid bits and calibration registers; no clearing pass.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer barometer compensation: raw temperature and pressure in,
// centidegrees and pascals out, calibration words from the write port.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input word: raw_temperature [19:0], raw_pressure [39:20].
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [39:0]                   i_s_tdata,
    // Result word: temperature_centi [17:0], pressure_pascal [49:18], zeros.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [55:0]                   o_m_tdata,
    // Result flag: divisor_zero [0].
    output logic [0:0]                    o_m_tuser,
    // Calibration write port.
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]    i_cfg_data
);
    import bptc_pkg::*;

    logic [CAL_W-1:0]   r_cal_t, r_cal_pa, r_cal_pb, r_cal_pc;
    t_calib             w_cal;
    logic               w_en;

    logic               w_t_vld;
    logic [TEMP_W-1:0]  w_t_temp;
    logic signed [32:0] w_t_v1;
    logic [RAW_W-1:0]   w_t_rp;

    logic               w_c_vld;
    logic [63:0]        w_c_mn;
    logic [DEN_W-1:0]   w_c_md;
    t_tag               w_c_tag;

    logic               w_d_vld;
    logic [63:0]        w_d_q;
    t_tag               w_d_tag;

    logic               w_p_vld;
    logic [TEMP_W-1:0]  w_p_temp;
    logic [PRESS_W-1:0] w_p_press;
    logic               w_p_dz;

    logic               r_out_v, r_skid_v, n_out_v, n_skid_v;
    logic               n_out_load, n_skid_load;
    logic [TEMP_W-1:0]  r_out_temp, r_skid_temp;
    logic [PRESS_W-1:0] r_out_press, r_skid_press;
    logic               r_out_dz, r_skid_dz;

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pa <= '0;
            r_cal_pb <= '0;
            r_cal_pc <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CAL_T:  r_cal_t  <= i_cfg_data;
                REG_CAL_PA: r_cal_pa <= i_cfg_data;
                REG_CAL_PB: r_cal_pb <= i_cfg_data;
                REG_CAL_PC: r_cal_pc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the calibration words.
    always_comb begin
        w_cal.t1 = r_cal_t[15:0];
        w_cal.t2 = r_cal_t[31:16];
        w_cal.t3 = r_cal_t[47:32];
        w_cal.p1 = r_cal_pa[15:0];
        w_cal.p2 = r_cal_pa[31:16];
        w_cal.p3 = r_cal_pa[47:32];
        w_cal.p4 = r_cal_pb[15:0];
        w_cal.p5 = r_cal_pb[31:16];
        w_cal.p6 = r_cal_pb[47:32];
        w_cal.p7 = r_cal_pc[15:0];
        w_cal.p8 = r_cal_pc[31:16];
        w_cal.p9 = r_cal_pc[47:32];
    end

    // The whole pipeline advances while the skid register is empty.
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    bptc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_raw_t (i_s_tdata[19:0]),
        .i_raw_p (i_s_tdata[39:20]),
        .i_cal   (w_cal),
        .o_vld   (w_t_vld),
        .o_temp  (w_t_temp),
        .o_v1    (w_t_v1),
        .o_raw_p (w_t_rp)
    );

    bptc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_t_vld),
        .i_v1    (w_t_v1),
        .i_raw_p (w_t_rp),
        .i_temp  (w_t_temp),
        .i_cal   (w_cal),
        .o_vld   (w_c_vld),
        .o_mn    (w_c_mn),
        .o_md    (w_c_md),
        .o_tag   (w_c_tag)
    );

    bptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_c_vld),
        .i_mn    (w_c_mn),
        .i_md    (w_c_md),
        .i_tag   (w_c_tag),
        .o_vld   (w_d_vld),
        .o_q     (w_d_q),
        .o_tag   (w_d_tag)
    );

    bptc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_q     (w_d_q),
        .i_tag   (w_d_tag),
        .i_cal   (w_cal),
        .o_vld   (w_p_vld),
        .o_temp  (w_p_temp),
        .o_press (w_p_press),
        .o_dz    (w_p_dz)
    );

    // Output register with skid: a stalled output parks one word aside.
    always_comb begin
        n_out_v     = r_out_v;
        n_skid_v    = r_skid_v;
        n_out_load  = 1'b0;
        n_skid_load = 1'b0;
        if (r_out_v && !i_m_tready) begin
            if (w_p_vld && !r_skid_v) begin
                n_skid_v    = 1'b1;
                n_skid_load = 1'b1;
            end
        end else if (r_skid_v) begin
            n_out_v  = 1'b1;
            n_skid_v = 1'b0;
        end else begin
            n_out_v    = w_p_vld;
            n_out_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_skid_load) begin
            r_skid_temp  <= w_p_temp;
            r_skid_press <= w_p_press;
            r_skid_dz    <= w_p_dz;
        end
        if (n_out_load) begin
            r_out_temp  <= w_p_temp;
            r_out_press <= w_p_press;
            r_out_dz    <= w_p_dz;
        end else if (!(r_out_v && !i_m_tready) && r_skid_v) begin
            r_out_temp  <= r_skid_temp;
            r_out_press <= r_skid_press;
            r_out_dz    <= r_skid_dz;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'd0, r_out_press, r_out_temp};
    assign o_m_tuser  = r_out_dz;

endmodule

// ===== hw/rtl/bptc_temp.sv =====
// ----------------------------------------------------------------------------
// bptc_temp
// Four-stage temperature compensation: fine value, centidegrees and the
// offset fine value that seeds the pressure path.
// ----------------------------------------------------------------------------
module bptc_temp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [bptc_pkg::RAW_W-1:0]    i_raw_t,
    input  logic [bptc_pkg::RAW_W-1:0]    i_raw_p,
    input  bptc_pkg::t_calib              i_cal,
    output logic                          o_vld,
    output logic [bptc_pkg::TEMP_W-1:0]   o_temp,
    output logic signed [32:0]            o_v1,
    output logic [bptc_pkg::RAW_W-1:0]    o_raw_p
);
    import bptc_pkg::*;

    logic [3:0]        r_vld;
    logic [RAW_W-1:0]  r_rp [4];

    logic signed [17:0] n_a;
    logic signed [16:0] n_b;
    logic signed [33:0] n_at2;
    logic signed [33:0] n_bb;
    logic [31:0]        r_a_at2;
    logic [31:0]        r_a_bb;

    logic signed [35:0] n_b_p;
    logic [20:0]        r_b_tv1;
    logic [31:0]        r_b_p;

    logic [31:0]        n_fine;
    logic [31:0]        r_c_fine;

    logic [31:0]        n_t32;
    logic signed [32:0] n_v1;
    logic [TEMP_W-1:0]  r_d_temp;
    logic signed [32:0] r_d_v1;

    // Stage A: scaled differences and first products.
    always_comb begin
        n_a   = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
        n_b   = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_cal.t1});
        n_at2 = n_a * i_cal.t2;
        n_bb  = n_b * n_b;
    end

    // Stage B: second-order term times T3.
    always_comb begin
        n_b_p = $signed(r_a_bb[31:12]) * i_cal.t3;
    end

    // Stage C: fine temperature.
    always_comb begin
        n_fine = {{11{r_b_tv1[20]}}, r_b_tv1} + {{14{r_b_p[31]}}, r_b_p[31:14]};
    end

    // Stage D: centidegrees and offset fine value.
    always_comb begin
        n_t32 = {r_c_fine[29:0], 2'b00} + r_c_fine + 32'd128;
        n_v1  = $signed({r_c_fine[31], r_c_fine}) - 33'sd128000;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[0]  <= i_raw_p;
            for (int k = 1; k < 4; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
            r_a_at2  <= n_at2[31:0];
            r_a_bb   <= n_bb[31:0];
            r_b_tv1  <= r_a_at2[31:11];
            r_b_p    <= n_b_p[31:0];
            r_c_fine <= n_fine;
            r_d_temp <= n_t32[25:8];
            r_d_v1   <= n_v1;
        end
    end

    assign o_vld   = r_vld[3];
    assign o_temp  = r_d_temp;
    assign o_v1    = r_d_v1;
    assign o_raw_p = r_rp[3];

endmodule

// ===== hw/rtl/bptc_coef.sv =====
// ----------------------------------------------------------------------------
// bptc_coef
// Eight-stage pressure coefficient path: builds the divider numerator and
// denominator with 64-bit wrapping arithmetic from split partial products.
// ----------------------------------------------------------------------------
module bptc_coef (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [32:0]            i_v1,
    input  logic [bptc_pkg::RAW_W-1:0]    i_raw_p,
    input  logic [bptc_pkg::TEMP_W-1:0]   i_temp,
    input  bptc_pkg::t_calib              i_cal,
    output logic                          o_vld,
    output logic [63:0]                   o_mn,
    output logic [bptc_pkg::DEN_W-1:0]    o_md,
    output bptc_pkg::t_tag                o_tag
);
    import bptc_pkg::*;

    logic [7:0]        r_vld;
    logic [RAW_W-1:0]  r_rp [4];
    logic [TEMP_W-1:0] r_tp [7];

    // Stage E
    logic [63:0]        n_e_sq;
    logic [31:0]        n_e_corr;
    logic signed [48:0] n_e_vp5, n_e_vp2;
    logic [63:0]        r_e_sq;
    logic [31:0]        r_e_corr;
    logic signed [48:0] r_e_vp5, r_e_vp2;
    // Stage F
    logic [63:0]        r_f_vv;
    logic signed [48:0] r_f_vp5, r_f_vp2;
    // Stage G
    logic signed [48:0] n_g_lo6, n_g_lo3;
    logic [31:0]        n_g_hi6, n_g_hi3;
    logic signed [48:0] r_g_lo6, r_g_lo3, r_g_vp5, r_g_vp2;
    logic [31:0]        r_g_hi6, r_g_hi3;
    // Stage H
    logic [63:0]        n_h_v2, n_h_t3, n_h_v1x;
    logic [63:0]        r_h_v2, r_h_v1x;
    // Stage I
    logic [20:0]        n_i_pd;
    logic [63:0]        n_i_w, n_i_num;
    logic [63:0]        r_i_w, r_i_num;
    // Stage J
    logic [47:0]        n_j_wlo;
    logic [31:0]        n_j_whi, n_j_nhi;
    logic [43:0]        n_j_nlo;
    logic [47:0]        r_j_wlo;
    logic [31:0]        r_j_whi, r_j_nhi;
    logic [43:0]        r_j_nlo;
    // Stage K
    logic [63:0]        n_k_wf, n_k_num;
    logic [DEN_W-1:0]   r_k_v1f;
    logic [63:0]        r_k_num;
    // Stage L
    t_tag               n_l_tag;
    logic [63:0]        n_l_mn;
    logic [DEN_W-1:0]   n_l_md;
    t_tag               r_l_tag;
    logic [63:0]        r_l_mn;
    logic [DEN_W-1:0]   r_l_md;

    // Stage E: square of the offset fine value and the linear products.
    always_comb begin
        n_e_sq   = {32'd0, i_v1[31:0]} * {32'd0, i_v1[31:0]};
        n_e_corr = i_v1[32] ? (32'd0 - {i_v1[30:0], 1'b0}) : 32'd0;
        n_e_vp5  = i_v1 * i_cal.p5;
        n_e_vp2  = i_v1 * i_cal.p2;
    end

    // Stage G: square times P6 and P3, split into low and high halves.
    always_comb begin
        n_g_lo6 = $signed({1'b0, r_f_vv[31:0]}) * i_cal.p6;
        n_g_hi6 = r_f_vv[63:32] * {{16{i_cal.p6[15]}}, i_cal.p6};
        n_g_lo3 = $signed({1'b0, r_f_vv[31:0]}) * i_cal.p3;
        n_g_hi3 = r_f_vv[63:32] * {{16{i_cal.p3[15]}}, i_cal.p3};
    end

    // Stage H: var2 and the first var1.
    always_comb begin
        n_h_v2  = {{15{r_g_lo6[48]}}, r_g_lo6} + {r_g_hi6, 32'd0}
                + {r_g_vp5[46:0], 17'd0}
                + {{13{i_cal.p4[15]}}, i_cal.p4, 35'd0};
        n_h_t3  = {{15{r_g_lo3[48]}}, r_g_lo3} + {r_g_hi3, 32'd0};
        n_h_v1x = {{8{n_h_t3[63]}}, n_h_t3[63:8]}
                + {{3{r_g_vp2[48]}}, r_g_vp2, 12'd0};
    end

    // Stage I: offset var1 and raw numerator.
    always_comb begin
        n_i_w   = r_h_v1x + 64'h0000_8000_0000_0000;
        n_i_pd  = 21'h10_0000 - {1'b0, r_rp[3]};
        n_i_num = {12'd0, n_i_pd, 31'd0} - r_h_v2;
    end

    // Stage J: partial products with P1 and the scale factor.
    always_comb begin
        n_j_wlo = {16'd0, r_i_w[31:0]} * {32'd0, i_cal.p1};
        n_j_whi = r_i_w[63:32] * {16'd0, i_cal.p1};
        n_j_nlo = {12'd0, r_i_num[31:0]} * {32'd0, PRESS_SCALE};
        n_j_nhi = r_i_num[63:32] * {20'd0, PRESS_SCALE};
    end

    // Stage K: combine halves; the denominator keeps 31 significant bits.
    always_comb begin
        n_k_wf  = {16'd0, r_j_wlo} + {r_j_whi, 32'd0};
        n_k_num = {20'd0, r_j_nlo} + {r_j_nhi, 32'd0};
    end

    // Stage L: magnitudes and quotient sign for the divider.
    always_comb begin
        n_l_tag.temp = r_tp[6];
        n_l_tag.dz   = (r_k_v1f == '0);
        n_l_tag.neg  = r_k_num[63] ^ r_k_v1f[DEN_W-1];
        n_l_mn       = r_k_num[63] ? (64'd0 - r_k_num) : r_k_num;
        n_l_md       = r_k_v1f[DEN_W-1] ? ('0 - r_k_v1f) : r_k_v1f;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[0] <= i_raw_p;
            for (int k = 1; k < 4; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
            r_tp[0] <= i_temp;
            for (int k = 1; k < 7; k++) begin
                r_tp[k] <= r_tp[k-1];
            end
            r_e_sq   <= n_e_sq;
            r_e_corr <= n_e_corr;
            r_e_vp5  <= n_e_vp5;
            r_e_vp2  <= n_e_vp2;
            r_f_vv   <= r_e_sq + {r_e_corr, 32'd0};
            r_f_vp5  <= r_e_vp5;
            r_f_vp2  <= r_e_vp2;
            r_g_lo6  <= n_g_lo6;
            r_g_hi6  <= n_g_hi6;
            r_g_lo3  <= n_g_lo3;
            r_g_hi3  <= n_g_hi3;
            r_g_vp5  <= r_f_vp5;
            r_g_vp2  <= r_f_vp2;
            r_h_v2   <= n_h_v2;
            r_h_v1x  <= n_h_v1x;
            r_i_w    <= n_i_w;
            r_i_num  <= n_i_num;
            r_j_wlo  <= n_j_wlo;
            r_j_whi  <= n_j_whi;
            r_j_nlo  <= n_j_nlo;
            r_j_nhi  <= n_j_nhi;
            r_k_v1f  <= n_k_wf[63:33];
            r_k_num  <= n_k_num;
            r_l_tag  <= n_l_tag;
            r_l_mn   <= n_l_mn;
            r_l_md   <= n_l_md;
        end
    end

    assign o_vld = r_vld[7];
    assign o_mn  = r_l_mn;
    assign o_md  = r_l_md;
    assign o_tag = r_l_tag;

endmodule

// ===== hw/rtl/bptc_div.sv =====
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The dividend register shifts out at the top while quotient bits enter
// at the bottom.
// ----------------------------------------------------------------------------
module bptc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [63:0]                   i_mn,
    input  logic [bptc_pkg::DEN_W-1:0]    i_md,
    input  bptc_pkg::t_tag                i_tag,
    output logic                          o_vld,
    output logic [63:0]                   o_q,
    output bptc_pkg::t_tag                o_tag
);
    import bptc_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DEN_W-1:0]      r_rem [DIV_STAGES];
    logic [63:0]           r_nq  [DIV_STAGES];
    logic [DEN_W-1:0]      r_md  [DIV_STAGES];
    t_tag                  r_tag [DIV_STAGES];

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    // One trial subtraction per stage.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DEN_W-1:0] w_rem;
        logic [63:0]      w_nq;
        logic [DEN_W-1:0] w_md;
        t_tag             w_tag;
        logic [DEN_W:0]   n_t;
        logic [DEN_W:0]   n_diff;
        logic             n_ge;

        if (k == 0) begin : g_src_in
            assign w_rem = '0;
            assign w_nq  = i_mn;
            assign w_md  = i_md;
            assign w_tag = i_tag;
        end else begin : g_src_reg
            assign w_rem = r_rem[k-1];
            assign w_nq  = r_nq[k-1];
            assign w_md  = r_md[k-1];
            assign w_tag = r_tag[k-1];
        end

        always_comb begin
            n_t    = {w_rem, w_nq[63]};
            n_diff = n_t - {1'b0, w_md};
            n_ge   = (n_t >= {1'b0, w_md});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[DEN_W-1:0] : n_t[DEN_W-1:0];
                r_nq[k]  <= {w_nq[62:0], n_ge};
                r_md[k]  <= w_md;
                r_tag[k] <= w_tag;
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_q   = r_nq[DIV_STAGES-1];
    assign o_tag = r_tag[DIV_STAGES-1];

endmodule

// ===== hw/rtl/bptc_post.sv =====
// ----------------------------------------------------------------------------
// bptc_post
// Seven-stage pressure finishing: quotient sign, P9 and P8 correction terms,
// P7 offset and the final scaling to pascals.
// ----------------------------------------------------------------------------
module bptc_post (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [63:0]                   i_q,
    input  bptc_pkg::t_tag                i_tag,
    input  bptc_pkg::t_calib              i_cal,
    output logic                          o_vld,
    output logic [bptc_pkg::TEMP_W-1:0]   o_temp,
    output logic [bptc_pkg::PRESS_W-1:0]  o_press,
    output logic                          o_dz
);
    import bptc_pkg::*;

    logic [6:0]         r_vld;
    t_tag               r_tag [7];

    logic [63:0]        r1_p, r2_p, r3_p, r4_p, r5_p;
    logic [63:0]        n2_ph, n2_sll;
    logic [31:0]        n2_slh, n2_p8hi;
    logic signed [48:0] n2_p8lo;
    logic [63:0]        r2_sll;
    logic [31:0]        r2_slh, r2_p8hi;
    logic signed [48:0] r2_p8lo;
    logic [63:0]        n3_sq, n3_t8;
    logic [63:0]        r3_sq;
    logic [44:0]        r3_w2, r4_w2, r5_w2;
    logic signed [48:0] n4_lo9;
    logic [31:0]        n4_hi9;
    logic signed [48:0] r4_lo9;
    logic [31:0]        r4_hi9;
    logic [63:0]        n5_t9;
    logic [38:0]        r5_w1;
    logic [63:0]        r6_s;
    logic [63:0]        n7_r;
    logic [PRESS_W-1:0] r7_press;

    // Stage 2: squared scaled pressure and P8 product, split in halves.
    always_comb begin
        n2_ph   = {{13{r1_p[63]}}, r1_p[63:13]};
        n2_sll  = {32'd0, n2_ph[31:0]} * {32'd0, n2_ph[31:0]};
        n2_slh  = n2_ph[31:0] * n2_ph[63:32];
        n2_p8lo = $signed({1'b0, r1_p[31:0]}) * i_cal.p8;
        n2_p8hi = r1_p[63:32] * {{16{i_cal.p8[15]}}, i_cal.p8};
    end

    // Stage 3: combine halves.
    always_comb begin
        n3_sq = r2_sll + {r2_slh[30:0], 33'd0};
        n3_t8 = {{15{r2_p8lo[48]}}, r2_p8lo} + {r2_p8hi, 32'd0};
    end

    // Stage 4: square times P9.
    always_comb begin
        n4_lo9 = $signed({1'b0, r3_sq[31:0]}) * i_cal.p9;
        n4_hi9 = r3_sq[63:32] * {{16{i_cal.p9[15]}}, i_cal.p9};
    end

    // Stage 5 and 7 combining logic.
    always_comb begin
        n5_t9 = {{15{r4_lo9[48]}}, r4_lo9} + {r4_hi9, 32'd0};
        n7_r  = {{8{r6_s[63]}}, r6_s[63:8]} + {{44{i_cal.p7[15]}}, i_cal.p7, 4'd0};
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 7; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r1_p     <= i_tag.neg ? (64'd0 - i_q) : i_q;
            r2_p     <= r1_p;
            r2_sll   <= n2_sll;
            r2_slh   <= n2_slh;
            r2_p8lo  <= n2_p8lo;
            r2_p8hi  <= n2_p8hi;
            r3_p     <= r2_p;
            r3_sq    <= n3_sq;
            r3_w2    <= n3_t8[63:19];
            r4_p     <= r3_p;
            r4_w2    <= r3_w2;
            r4_lo9   <= n4_lo9;
            r4_hi9   <= n4_hi9;
            r5_p     <= r4_p;
            r5_w2    <= r4_w2;
            r5_w1    <= n5_t9[63:25];
            r6_s     <= r5_p + {{25{r5_w1[38]}}, r5_w1} + {{19{r5_w2[44]}}, r5_w2};
            r7_press <= r_tag[5].dz ? '0 : n7_r[39:8];
        end
    end

    assign o_vld   = r_vld[6];
    assign o_temp  = r_tag[6].temp;
    assign o_press = r7_press;
    assign o_dz    = r_tag[6].dz;

endmodule

// ===== hw/rtl/bptc_checker.sv =====
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks of the compensation block, attached by bind.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"

module bptc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [55:0]                   o_m_tdata,
    input logic [0:0]                    o_m_tuser
);
    logic        w_stall;
    logic [56:0] w_word;
    logic [31:0] w_press;

    // Handy views of the result side.
    assign w_stall = o_m_tvalid && !i_m_tready;
    assign w_word  = {o_m_tuser, o_m_tdata};
    assign w_press = o_m_tdata[49:18];

    // A stalled result word holds still.
    `BPTC_ASSERT_CLK(a_out_hold, w_stall |=> o_m_tvalid && $stable(w_word), "stalled word changed")

    // A zero divisor always comes with zero pressure.
    `BPTC_ASSERT_CLK(a_dz_zero, o_m_tvalid && o_m_tuser[0] |-> w_press == '0, "pressure not zero")

    // The input only backs up behind a waiting result.
    `BPTC_ASSERT_CLK(a_busy_out, !o_s_tready |-> o_m_tvalid, "input stalled with no result")

    // Once the result is taken, the skid word moves up and the input reopens.
    `BPTC_ASSERT_CLK(a_reopen, !o_s_tready && i_m_tready |=> o_s_tready && o_m_tvalid, "no reopen")

endmodule

bind baro_temp_pressure_compensation bptc_checker u_bptc_checker (.*);

// ===== sim/baro_temp_pressure_compensation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Streams raw temperature and pressure readings through the block under
// several calibration settings. A scoreboard predicts each result in 32-bit
// and 64-bit wrapping arithmetic and compares it field by field.
// ----------------------------------------------------------------------------

// Scoreboard: predicts each result from the calibration and holds the queue.
class baro_scoreboard;
    logic [47:0]  cal_words [4];
    logic [17:0]  temp_q [$];
    logic [31:0]  press_q [$];
    logic         dz_q [$];
    int           errors;

    function new();
        for (int i = 0; i < 4; i++) cal_words[i] = '0;
        errors = 0;
    endfunction

    function void write_cal(int idx, logic [47:0] val);
        if (idx < 4) cal_words[idx] = val;
    endfunction

    function logic signed [63:0] sword(int r, int k);
        return 64'(signed'(cal_words[r][16*k +: 16]));
    endfunction

    // Computes the compensated result for one reading pair and queues it.
    function void note_reading(logic [19:0] adc_t, logic [19:0] adc_p);
        logic signed [31:0] t1, t2, t3, a, tv1, b, tv2, fine, temp;
        logic signed [63:0] v1, v2, tf, p, ph, w1, w2, num, den, nq;
        logic [63:0] mn, md, q;
        logic dz;
        t1 = {16'd0, cal_words[0][15:0]};
        t2 = 32'(sword(0, 1));
        t3 = 32'(sword(0, 2));
        a = 32'(adc_t >> 3) - (t1 <<< 1);
        tv1 = (a * t2) >>> 11;
        b = 32'(adc_t >> 4) - t1;
        tv2 = (((b * b) >>> 12) * t3) >>> 14;
        fine = tv1 + tv2;
        temp = (fine * 5 + 128) >>> 8;

        tf = 64'(fine);
        v1 = tf - 128000;
        v2 = v1 * v1 * sword(2, 2);
        v2 = v2 + ((v1 * sword(2, 1)) <<< 17);
        v2 = v2 + (sword(2, 0) <<< 35);
        v1 = ((v1 * v1 * sword(1, 2)) >>> 8) + ((v1 * sword(1, 1)) <<< 12);
        den = (((64'sd1 <<< 47) + v1) * $signed({48'd0, cal_words[1][15:0]})) >>> 33;
        dz = (den == 0);
        p = 0;
        if (!dz) begin
            p = 64'sd1048576 - $signed({44'd0, adc_p});
            num = ((p <<< 31) - v2) * 3125;
            mn = num[63] ? -num : num;
            md = den[63] ? -den : den;
            q = mn / md;
            nq = (num[63] != den[63]) ? -$signed(q) : $signed(q);
            p = nq;
            ph = p >>> 13;
            w1 = (sword(3, 2) * ph * ph) >>> 25;
            w2 = (sword(3, 1) * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (sword(3, 0) <<< 4);
            p = p >>> 8;
        end
        temp_q.push_back(temp[17:0]);
        press_q.push_back(p[31:0]);
        dz_q.push_back(dz);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Compares one accepted result word with the oldest prediction.
    task check_result(logic [55:0] data, logic dz);
        if (temp_q.size() == 0) begin
            report_mismatch("unexpected result", data, 0);
            return;
        end
        if (data[17:0] !== temp_q[0]) report_mismatch("temperature", data[17:0], temp_q[0]);
        if (data[49:18] !== press_q[0]) report_mismatch("pressure", data[49:18], press_q[0]);
        if (dz !== dz_q[0]) report_mismatch("divisor_zero", dz, dz_q[0]);
        if (data[55:50] !== 0) report_mismatch("padding", data[55:50], 0);
        void'(temp_q.pop_front());
        void'(press_q.pop_front());
        void'(dz_q.pop_front());
    endtask

    function int pending();
        return temp_q.size();
    endfunction
endclass

module baro_temp_pressure_compensation_test;
    import bptc_pkg::*;

    localparam int LATENCY = 83;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_CAL_T;
    logic [47:0] i_cfg_data = '0;

    baro_scoreboard sb = new();
    bit quiet_phase = 0;   // no idling on either side
    bit hold_off = 0;      // receiver stalls for a long stretch

    baro_temp_pressure_compensation u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser[0]);
    end

    // Offers one reading pair and waits until it is taken.
    task send_reading(logic [19:0] adc_t, logic [19:0] adc_p);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {adc_p, adc_t};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_reading(adc_t, adc_p);
    endtask

    task go_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // One register write, after which the write enable is dropped again.
    task write_cal(t_cfg_reg idx, logic [47:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_cal(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Typical calibration: realistic sensor words give sane pressures.
    task load_typical();
        write_cal(REG_CAL_T,  {16'hFF9C, 16'd26435, 16'd27504});
        write_cal(REG_CAL_PA, {16'd3024, 16'hD6D0, 16'd36477});
        write_cal(REG_CAL_PB, {16'hFFF9, 16'hFF8C, 16'd2855});
        write_cal(REG_CAL_PC, {16'd6000, 16'hC5F8, 16'd15500});
    endtask

    task random_readings(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_reading(20'($urandom), 20'($urandom));
            else
                send_reading(20'($urandom_range(400000, 600000)),
                             20'($urandom_range(300000, 500000)));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero calibration after reset: divisor is zero.
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        go_idle();

        // Directed corners under typical calibration.
        load_typical();
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        go_idle();

        // Extreme calibration words, overflow and sign corners.
        write_cal(REG_CAL_T,  48'hFFFF_FFFF_FFFF);
        write_cal(REG_CAL_PA, 48'h8000_8000_FFFF);
        write_cal(REG_CAL_PB, 48'h7FFF_7FFF_7FFF);
        write_cal(REG_CAL_PC, 48'h8000_8000_8000);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h12345, 20'h80000);
        go_idle();
        write_cal(REG_CAL_T,  48'h7FFF_8000_0000);
        write_cal(REG_CAL_PA, 48'h7FFF_7FFF_0001);
        write_cal(REG_CAL_PB, 48'h8000_8000_8000);
        write_cal(REG_CAL_PC, 48'h7FFF_7FFF_7FFF);
        send_reading(20'hFFFFF, 20'd1);
        send_reading(20'd1, 20'hFFFFE);
        go_idle();

        // Random readings with typical calibration, including a long stall.
        load_typical();
        hold_off = 1;
        random_readings(600);
        go_idle();

        // Random calibration words in several phases.
        for (int ph = 0; ph < 4; ph++) begin
            write_cal(REG_CAL_T, rand48());
            write_cal(REG_CAL_PA, rand48());
            write_cal(REG_CAL_PB, rand48());
            write_cal(REG_CAL_PC, rand48());
            random_readings(150);
            go_idle();
        end

        // Final stretch at full rate, no idling.
        load_typical();
        quiet_phase = 1;
        random_readings(400);
        go_idle();

        if (sb.errors == 0)
            $display("baro_temp_pressure_compensation verification clean");
        else
            $display("baro_temp_pressure_compensation verification failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("baro_temp_pressure_compensation verification failed");
        $finish;
    end
endmodule
